/* sv/pnma_pkg.sv */
// shared types and constants of the palette nearest match allocator
`timescale 1ns / 1ps

package pnma_pkg;

   // field widths
   localparam int WANT_W      = 12;
   localparam int COMP_W      = 8;
   localparam int COLOUR_W    = 3 * COMP_W;
   localparam int WORD_W      = COLOUR_W + 1;
   localparam int FLAG_BIT    = COLOUR_W;
   localparam int LIMIT_W     = 31;
   localparam int WEIGHT_W    = 10;
   localparam int SHADE_W     = 6;
   localparam int COEF_W      = 15;
   localparam int SQ_W        = 16;
   localparam int TERM_W      = COEF_W + SQ_W;
   localparam int DIST_W      = TERM_W + 2;
   localparam int IDX_OUT_W   = 9;
   localparam int CNT_OUT_W   = 9;
   localparam int CSR_IDX_W   = 2;

   // constants of the distance formula
   localparam logic [LIMIT_W-1:0] DIST_SAT   = 31'h7fff_ffff;
   localparam logic [SHADE_W-1:0] SHADE_BASE = 6'd32;
   localparam logic [COMP_W-1:0]  COMP_MAX   = 8'd255;
   localparam logic [COLOUR_W-1:0] WHITE     = 24'hff_ffff;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_RED   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_GREEN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_BLUE  = 2'd2;
   localparam logic [WEIGHT_W-1:0]  WEIGHT_RED_RST   = 10'd299;
   localparam logic [WEIGHT_W-1:0]  WEIGHT_GREEN_RST = 10'd587;
   localparam logic [WEIGHT_W-1:0]  WEIGHT_BLUE_RST  = 10'd114;

   // request commands
   localparam logic CMD_FIND  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   // control bits that travel along the scan pipeline
   typedef struct packed {
      logic valid;
      logic last;
      logic flag;
   } scan_tag_type;

endpackage

/* sv/pnma_req_if.sv */
// request channel of the palette nearest match allocator
`timescale 1ns / 1ps

interface pnma_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 cmd;
   logic signed [pnma_pkg::WANT_W-1:0]   want_red;
   logic signed [pnma_pkg::WANT_W-1:0]   want_green;
   logic signed [pnma_pkg::WANT_W-1:0]   want_blue;
   logic        [pnma_pkg::LIMIT_W-1:0]  accept_limit;

   modport source (
      output valid, cmd, want_red, want_green, want_blue, accept_limit,
      input  ready
   );
   modport sink (
      input  valid, cmd, want_red, want_green, want_blue, accept_limit,
      output ready
   );
endinterface

/* sv/pnma_rsp_if.sv */
// response channel of the palette nearest match allocator
`timescale 1ns / 1ps

interface pnma_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [pnma_pkg::IDX_OUT_W-1:0] entry_index;
   logic        [pnma_pkg::LIMIT_W-1:0]   best_distance;
   logic                                  newly_allocated;
   logic        [pnma_pkg::CNT_OUT_W-1:0] free_entries;

   modport source (
      output valid, entry_index, best_distance, newly_allocated, free_entries,
      input  ready
   );
   modport sink (
      input  valid, entry_index, best_distance, newly_allocated, free_entries,
      output ready
   );
endinterface

/* sv/pnma_ram.sv */
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module pnma_ram #(
   parameter int WIDTH = 25,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/pnma_dist.sv */
// three stage weighted colour distance pipeline
`timescale 1ns / 1ps

module pnma_dist #(
   parameter int IDX_W = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pnma_pkg::scan_tag_type            in_tag,
   input  logic [IDX_W-1:0]                  in_idx,
   input  logic [pnma_pkg::COLOUR_W-1:0]     in_colour,
   input  logic [pnma_pkg::COMP_W-1:0]       tgt_red,
   input  logic [pnma_pkg::COMP_W-1:0]       tgt_green,
   input  logic [pnma_pkg::COMP_W-1:0]       tgt_blue,
   input  logic [pnma_pkg::COEF_W-1:0]       coef_red,
   input  logic [pnma_pkg::COEF_W-1:0]       coef_green,
   input  logic [pnma_pkg::COEF_W-1:0]       coef_blue,
   output pnma_pkg::scan_tag_type            out_tag,
   output logic [IDX_W-1:0]                  out_idx,
   output logic [pnma_pkg::DIST_W-1:0]       out_dist
);

   localparam int CW = pnma_pkg::COMP_W;
   localparam int PW = 2 * CW + 2;
   localparam int TW = pnma_pkg::TERM_W;

   pnma_pkg::scan_tag_type tag_a_ff, tag_b_ff, tag_c_ff;
   logic [IDX_W-1:0] idx_a_ff, idx_b_ff, idx_c_ff;

   logic signed [CW:0]       diff_r, diff_g, diff_b;
   logic signed [2*CW+1:0]   prod_r, prod_g, prod_b;
   logic [pnma_pkg::SQ_W-1:0]   sq_r_ff, sq_g_ff, sq_b_ff;
   logic [pnma_pkg::TERM_W-1:0] term_r_ff, term_g_ff, term_b_ff;
   logic [pnma_pkg::DIST_W-1:0] dist_ff;

   // stage a: squared component differences
   always_comb begin
      diff_r = $signed({1'b0, in_colour[3*CW-1:2*CW]}) - $signed({1'b0, tgt_red});
      diff_g = $signed({1'b0, in_colour[2*CW-1:CW]})   - $signed({1'b0, tgt_green});
      diff_b = $signed({1'b0, in_colour[CW-1:0]})      - $signed({1'b0, tgt_blue});
      prod_r = PW'(diff_r) * PW'(diff_r);
      prod_g = PW'(diff_g) * PW'(diff_g);
      prod_b = PW'(diff_b) * PW'(diff_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
         tag_c_ff <= '0;
      end else begin
         tag_a_ff <= in_tag;
         tag_b_ff <= tag_a_ff;
         tag_c_ff <= tag_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_a_ff  <= in_idx;
      sq_r_ff   <= prod_r[pnma_pkg::SQ_W-1:0];
      sq_g_ff   <= prod_g[pnma_pkg::SQ_W-1:0];
      sq_b_ff   <= prod_b[pnma_pkg::SQ_W-1:0];
      // stage b: scale by the per-request coefficients
      idx_b_ff  <= idx_a_ff;
      term_r_ff <= TW'(coef_red)   * TW'(sq_r_ff);
      term_g_ff <= TW'(coef_green) * TW'(sq_g_ff);
      term_b_ff <= TW'(coef_blue)  * TW'(sq_b_ff);
      // stage c: sum of the three terms
      idx_c_ff  <= idx_b_ff;
      dist_ff   <= {2'b00, term_r_ff} + {2'b00, term_g_ff} + {2'b00, term_b_ff};
   end

   assign out_tag  = tag_c_ff;
   assign out_idx  = idx_c_ff;
   assign out_dist = dist_ff;

endmodule

/* sv/palette_nearest_match_allocator_core.sv */
// top level of the palette nearest match allocator
`timescale 1ns / 1ps

// Palette nearest match allocator. The palette (colour plus in-use flag per
// entry) lives in one ram with a single read and a single write port. After
// reset a clearing pass writes every entry, during which req_if.ready stays
// low; entry 0 is black, the last entry white, both in use. Each request is
// then handled alone: a setup state, a scan that reads entries 1 to
// TABLE_ENTRIES-1 one per cycle through the ram read port, a drain of the ram
// read register and the distance pipeline, a decision state that also writes a
// newly allocated entry and the idle state in which the next request is taken.
// The response sits in an output register, so a new request is taken while the
// previous response still waits for its transfer; the decision of that new
// request then waits until the older response has gone.
// Weights must be written over the csr port only while no request is in
// flight; the block itself does not enforce it.

module palette_nearest_match_allocator_core #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [pnma_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pnma_pkg::WEIGHT_W-1:0]       csr_wdata,
   pnma_req_if.sink                            req_if,
   pnma_rsp_if.source                          rsp_if
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IXW   = (IDX_W > pnma_pkg::IDX_OUT_W) ? IDX_W : pnma_pkg::IDX_OUT_W;
   localparam int CXW   = (CNT_W > pnma_pkg::CNT_OUT_W) ? CNT_W : pnma_pkg::CNT_OUT_W;
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(1);
   localparam logic [CNT_W-1:0] FREE_RST  = CNT_W'(TABLE_ENTRIES - 2);

   localparam int CW  = pnma_pkg::COMP_W;
   localparam int DW  = pnma_pkg::DIST_W;
   localparam int CFW = pnma_pkg::COEF_W + 1;

   // sequencer states
   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;

   // configuration
   logic [pnma_pkg::WEIGHT_W-1:0] weight_red_ff, weight_green_ff, weight_blue_ff;

   // captured request
   logic                          cmd_ff;
   logic [CW-1:0]                 tr_ff, tg_ff, tb_ff;
   logic [pnma_pkg::LIMIT_W-1:0]  limit_ff;
   logic [pnma_pkg::COEF_W-1:0]   coef_r_ff, coef_g_ff, coef_b_ff;

   // scan results
   logic             found_ff;
   logic [DW-1:0]    best_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic             free_found_ff;
   logic [IDX_W-1:0] free_idx_ff;
   logic [CNT_W-1:0] free_cnt_ff;

   // response register
   logic                                  rsp_valid_ff;
   logic [pnma_pkg::IDX_OUT_W-1:0]        rsp_index_ff;
   logic [pnma_pkg::LIMIT_W-1:0]          rsp_dist_ff;
   logic                                  rsp_new_ff;
   logic [pnma_pkg::CNT_OUT_W-1:0]        rsp_free_ff;

   // ram and pipeline
   logic                          ram_wr_en;
   logic [IDX_W-1:0]              ram_wr_addr;
   logic [pnma_pkg::WORD_W-1:0]   ram_wr_data;
   logic [pnma_pkg::WORD_W-1:0]   ram_rd_data;
   pnma_pkg::scan_tag_type        rd_tag_ff;
   logic [IDX_W-1:0]              rd_idx_ff;
   pnma_pkg::scan_tag_type        dist_in_tag, dist_out_tag;
   logic [IDX_W-1:0]              dist_out_idx;
   logic [DW-1:0]                 dist_out;

   // decision
   logic             req_xfer;
   logic             slot_free;
   logic             finish;
   logic             over_limit;
   logic             take;
   logic [CNT_W-1:0] free_cnt_next;
   logic [IXW-1:0]   idx_ext;
   logic [CXW-1:0]   cnt_ext;

   // setup arithmetic
   logic [CW-1:0]                 tmax;
   logic [pnma_pkg::SHADE_W-1:0]  shade_r, shade_g, shade_b;
   logic [pnma_pkg::COEF_W:0]     coef_r_full, coef_g_full, coef_b_full;

   function automatic logic [CW-1:0] clamp_comp(input logic signed [pnma_pkg::WANT_W-1:0] raw);
      logic [CW-1:0] res;
      if (raw < 0) begin
         res = '0;
      end else if (raw > $signed({{(pnma_pkg::WANT_W-CW){1'b0}}, pnma_pkg::COMP_MAX})) begin
         res = pnma_pkg::COMP_MAX;
      end else begin
         res = raw[CW-1:0];
      end
      return res;
   endfunction

   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;
   assign slot_free    = !rsp_valid_ff || rsp_if.ready;
   assign finish       = (state_ff == ST_DONE) && slot_free;

   // per-request shade factors and coefficients
   always_comb begin
      tmax = tr_ff;
      if (tg_ff > tmax) begin
         tmax = tg_ff;
      end
      if (tb_ff > tmax) begin
         tmax = tb_ff;
      end
      shade_r = pnma_pkg::SHADE_BASE - pnma_pkg::SHADE_W'((tmax - tr_ff) >> 3);
      shade_g = pnma_pkg::SHADE_BASE - pnma_pkg::SHADE_W'((tmax - tg_ff) >> 3);
      shade_b = pnma_pkg::SHADE_BASE - pnma_pkg::SHADE_W'((tmax - tb_ff) >> 3);
      coef_r_full = CFW'(weight_red_ff)   * CFW'(shade_r);
      coef_g_full = CFW'(weight_green_ff) * CFW'(shade_g);
      coef_b_full = CFW'(weight_blue_ff)  * CFW'(shade_b);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      case (state_ff)
         ST_INIT: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            addr_in = FIRST_IDX;
            if (req_xfer) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (dist_out_tag.valid && dist_out_tag.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         addr_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
      end
   end

   // configuration writes, out of range indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_red_ff   <= pnma_pkg::WEIGHT_RED_RST;
         weight_green_ff <= pnma_pkg::WEIGHT_GREEN_RST;
         weight_blue_ff  <= pnma_pkg::WEIGHT_BLUE_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            pnma_pkg::CSR_WEIGHT_RED:   weight_red_ff   <= csr_wdata;
            pnma_pkg::CSR_WEIGHT_GREEN: weight_green_ff <= csr_wdata;
            pnma_pkg::CSR_WEIGHT_BLUE:  weight_blue_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // request capture and coefficient setup
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff   <= req_if.cmd;
         tr_ff    <= clamp_comp(req_if.want_red);
         tg_ff    <= clamp_comp(req_if.want_green);
         tb_ff    <= clamp_comp(req_if.want_blue);
         limit_ff <= req_if.accept_limit;
      end
      if (state_ff == ST_SETUP) begin
         coef_r_ff <= coef_r_full[pnma_pkg::COEF_W-1:0];
         coef_g_ff <= coef_g_full[pnma_pkg::COEF_W-1:0];
         coef_b_ff <= coef_b_full[pnma_pkg::COEF_W-1:0];
      end
   end

   // ram write: clearing pass after reset, new entry at the end of a request
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = addr_ff;
      ram_wr_data = '0;
      if (state_ff == ST_INIT) begin
         ram_wr_en = 1'b1;
         if (addr_ff == '0) begin
            ram_wr_data = {1'b1, {pnma_pkg::COLOUR_W{1'b0}}};
         end else if (addr_ff == LAST_IDX) begin
            ram_wr_data = {1'b1, pnma_pkg::WHITE};
         end
      end else if (finish && take) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = free_idx_ff;
         ram_wr_data = {1'b1, tr_ff, tg_ff, tb_ff};
      end
   end

   pnma_ram #(
      .WIDTH (pnma_pkg::WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // tag that lines up with the registered ram read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tag_ff <= '0;
      end else begin
         rd_tag_ff.valid <= (state_ff == ST_SCAN);
         rd_tag_ff.last  <= (addr_ff == LAST_IDX);
         rd_tag_ff.flag  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
   end

   always_comb begin
      dist_in_tag       = rd_tag_ff;
      dist_in_tag.flag  = ram_rd_data[pnma_pkg::FLAG_BIT];
   end

   pnma_dist #(
      .IDX_W (IDX_W)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .in_tag     (dist_in_tag),
      .in_idx     (rd_idx_ff),
      .in_colour  (ram_rd_data[pnma_pkg::COLOUR_W-1:0]),
      .tgt_red    (tr_ff),
      .tgt_green  (tg_ff),
      .tgt_blue   (tb_ff),
      .coef_red   (coef_r_ff),
      .coef_green (coef_g_ff),
      .coef_blue  (coef_b_ff),
      .out_tag    (dist_out_tag),
      .out_idx    (dist_out_idx),
      .out_dist   (dist_out)
   );

   // best match and first free entry; entry 0 is always in use
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else if (req_xfer) begin
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (dist_out_tag.valid && dist_out_tag.flag && (!found_ff || dist_out < best_ff)) begin
            found_ff <= 1'b1;
         end
         if (dist_in_tag.valid && !dist_in_tag.flag) begin
            free_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      // strict compare keeps the lowest index on ties
      if (dist_out_tag.valid && dist_out_tag.flag && (!found_ff || dist_out < best_ff)) begin
         best_ff     <= dist_out;
         best_idx_ff <= dist_out_idx;
      end
      if (dist_in_tag.valid && !dist_in_tag.flag && !free_found_ff) begin
         free_idx_ff <= rd_idx_ff;
      end
   end

   // decision at the end of the scan
   always_comb begin
      over_limit    = best_ff > {{(DW - pnma_pkg::LIMIT_W){1'b0}}, limit_ff};
      take          = (cmd_ff == pnma_pkg::CMD_ALLOC) && (!found_ff || over_limit)
                      && free_found_ff;
      free_cnt_next = free_cnt_ff;
      if (take && (free_cnt_ff != '0)) begin
         free_cnt_next = free_cnt_ff - 1'b1;
      end
      idx_ext = take ? IXW'(free_idx_ff) : IXW'(best_idx_ff);
      cnt_ext = CXW'(free_cnt_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_cnt_ff <= FREE_RST;
      end else if (finish) begin
         free_cnt_ff <= free_cnt_next;
      end
   end

   // response register, one transfer per request
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         if (take || found_ff) begin
            rsp_index_ff <= idx_ext[pnma_pkg::IDX_OUT_W-1:0];
         end else begin
            rsp_index_ff <= '1;
         end
         if (!found_ff || (best_ff > {{(DW - pnma_pkg::LIMIT_W){1'b0}}, pnma_pkg::DIST_SAT})) begin
            rsp_dist_ff <= pnma_pkg::DIST_SAT;
         end else begin
            rsp_dist_ff <= best_ff[pnma_pkg::LIMIT_W-1:0];
         end
         rsp_new_ff  <= take;
         rsp_free_ff <= cnt_ext[pnma_pkg::CNT_OUT_W-1:0];
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.entry_index     = $signed(rsp_index_ff);
   assign rsp_if.best_distance   = rsp_dist_ff;
   assign rsp_if.newly_allocated = rsp_new_ff;
   assign rsp_if.free_entries    = rsp_free_ff;

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench of the palette nearest match allocator core
`timescale 1ns / 1ps

module tb_top;
   import pnma_pkg::*;

   localparam int ENTRIES      = 256;
   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 7;
   // a correct run is about 1550 requests after the clearing pass, well within the limit
   localparam int CYCLE_LIMIT  = 2_000_000;
   // one full request time and some margin after the last response
   localparam int DRAIN_CYCLES = ENTRIES + 40;
   // register index with no register behind it, writes are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic                     cmd;
      logic signed [WANT_W-1:0] red;
      logic signed [WANT_W-1:0] green;
      logic signed [WANT_W-1:0] blue;
      logic [LIMIT_W-1:0]       limit;
   } colour_request_type;

   typedef struct {
      logic signed [IDX_OUT_W-1:0] index;
      logic [LIMIT_W-1:0]          distance;
      logic                        allocated;
      logic [CNT_OUT_W-1:0]        free_left;
   } palette_answer_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WEIGHT_W-1:0]  csr_wdata;

   pnma_req_if req_if ();
   pnma_rsp_if rsp_if ();

   palette_nearest_match_allocator_core #(
      .TABLE_ENTRIES (ENTRIES)
   ) i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_if       (req_if),
      .rsp_if       (rsp_if)
   );

   always #HALF_PERIOD clock = ~clock;

   // shadow copy of the palette and the weights
   logic [COLOUR_W-1:0] shadow_colour [ENTRIES];
   bit                  shadow_used   [ENTRIES];
   int unsigned         shadow_free;
   logic [WEIGHT_W-1:0] gain_red;
   logic [WEIGHT_W-1:0] gain_green;
   logic [WEIGHT_W-1:0] gain_blue;

   colour_request_type colour_requests [$];   // waiting to be driven
   palette_answer_type awaited_answers [$];   // predicted, oldest first
   colour_request_type taken_request;
   palette_answer_type oldest_answer;

   int          send_idle_pct;
   int          recv_idle_pct;
   int          mismatches  = 0;
   int unsigned cycle_count = 0;

   // ---------------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------------

   // negative requests go to zero, anything above full scale saturates
   function automatic logic [COMP_W-1:0] clamp_want(input logic signed [WANT_W-1:0] raw);
      if (raw < 0) return '0;
      if (raw > COMP_MAX) return COMP_MAX;
      return raw[COMP_W-1:0];
   endfunction

   // one colour channel: gain * diff^2 * shade, shade shrinks for dim channels
   function automatic longint unsigned channel_cost(input logic [WEIGHT_W-1:0] gain,
                                                    input logic [COMP_W-1:0]   stored,
                                                    input logic [COMP_W-1:0]   target,
                                                    input logic [COMP_W-1:0]   peak);
      longint unsigned diff;
      longint unsigned shade;
      diff  = (stored > target) ? stored - target : target - stored;
      shade = SHADE_BASE - ((peak - target) >> 3);
      return gain * diff * diff * shade;
   endfunction

   // scan entries 1..last for the cheapest match; an alloc request allocates on a miss or over the limit
   function automatic palette_answer_type nearest_entry_lookup(input colour_request_type rq);
      logic [COMP_W-1:0]  tr, tg, tb, tm;
      longint unsigned    cost;
      longint unsigned    best_cost;
      bit                 found;
      bit                 took;
      int                 best_at;
      int                 chosen;
      int                 i;
      palette_answer_type ans;
      tr = clamp_want(rq.red);
      tg = clamp_want(rq.green);
      tb = clamp_want(rq.blue);
      tm = tr;
      if (tg > tm) tm = tg;
      if (tb > tm) tm = tb;
      found     = 1'b0;
      took      = 1'b0;
      best_cost = 0;
      best_at   = 0;
      chosen    = -1;
      // entry 0 never takes part in the search
      for (i = 1; i < ENTRIES; i++) begin
         if (shadow_used[i]) begin
            cost = channel_cost(gain_red,   shadow_colour[i][2*COMP_W +: COMP_W], tr, tm)
                 + channel_cost(gain_green, shadow_colour[i][COMP_W +: COMP_W],   tg, tm)
                 + channel_cost(gain_blue,  shadow_colour[i][0 +: COMP_W],        tb, tm);
            // strict less-than keeps the lowest index on a tie
            if (!found || cost < best_cost) begin
               found     = 1'b1;
               best_cost = cost;
               best_at   = i;
            end
         end
      end
      if (found) chosen = best_at;
      // full-width compare against the limit, saturation only on the report
      if (rq.cmd == CMD_ALLOC && (!found || best_cost > rq.limit)) begin
         for (i = 0; i < ENTRIES; i++) begin
            if (!shadow_used[i]) begin
               shadow_used[i]   = 1'b1;
               shadow_colour[i] = {tr, tg, tb};
               if (shadow_free > 0) shadow_free--;
               chosen = i;
               took   = 1'b1;
               break;
            end
         end
      end
      ans.index     = chosen[IDX_OUT_W-1:0];
      ans.distance  = (!found || best_cost > DIST_SAT) ? DIST_SAT : best_cost[LIMIT_W-1:0];
      ans.allocated = took;
      ans.free_left = shadow_free[CNT_OUT_W-1:0];
      return ans;
   endfunction

   // ---------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatches++;
      $display("mismatch on %s: got %0d, expected %0d, cycle %0d",
               what, got, want, cycle_count);
   endtask

   // ---------------------------------------------------------------------------
   // request driver, fed from colour_requests
   // ---------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid        <= 1'b0;
         req_if.cmd          <= CMD_FIND;
         req_if.want_red     <= '0;
         req_if.want_green   <= '0;
         req_if.want_blue    <= '0;
         req_if.accept_limit <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         // previous transfer done or nothing on the wire, maybe idle this cycle
         if (colour_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            taken_request = colour_requests.pop_front();
            req_if.valid        <= 1'b1;
            req_if.cmd          <= taken_request.cmd;
            req_if.want_red     <= taken_request.red;
            req_if.want_green   <= taken_request.green;
            req_if.want_blue    <= taken_request.blue;
            req_if.accept_limit <= taken_request.limit;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: checks response transfers, predicts on request transfers
   // ---------------------------------------------------------------------------

   colour_request_type seen_request;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch("response with nothing awaited", rsp_if.entry_index, 0);
            end else begin
               oldest_answer = awaited_answers.pop_front();
               if (rsp_if.entry_index !== oldest_answer.index)
                  report_mismatch("entry_index", rsp_if.entry_index, oldest_answer.index);
               if (rsp_if.best_distance !== oldest_answer.distance)
                  report_mismatch("best_distance", rsp_if.best_distance,
                                  oldest_answer.distance);
               if (rsp_if.newly_allocated !== oldest_answer.allocated)
                  report_mismatch("newly_allocated", rsp_if.newly_allocated,
                                  oldest_answer.allocated);
               if (rsp_if.free_entries !== oldest_answer.free_left)
                  report_mismatch("free_entries", rsp_if.free_entries,
                                  oldest_answer.free_left);
            end
         end
         // predict from what actually sits on the wire at the transfer
         if (req_if.valid && req_if.ready) begin
            seen_request.cmd   = req_if.cmd;
            seen_request.red   = req_if.want_red;
            seen_request.green = req_if.want_green;
            seen_request.blue  = req_if.want_blue;
            seen_request.limit = req_if.accept_limit;
            awaited_answers.push_back(nearest_entry_lookup(seen_request));
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // block idle: nothing queued, nothing on the wire, every answer back
   task automatic wait_idle();
      do @(negedge clock);
      while (colour_requests.size() != 0 || req_if.valid || awaited_answers.size() != 0);
   endtask

   task automatic write_weight(input logic [CSR_IDX_W-1:0] idx,
                               input logic [WEIGHT_W-1:0]  value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         CSR_WEIGHT_RED:   gain_red   = value;
         CSR_WEIGHT_GREEN: gain_green = value;
         CSR_WEIGHT_BLUE:  gain_blue  = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_weights(input logic [WEIGHT_W-1:0] red,
                              input logic [WEIGHT_W-1:0] green,
                              input logic [WEIGHT_W-1:0] blue);
      wait_idle();
      write_weight(CSR_WEIGHT_RED, red);
      write_weight(CSR_WEIGHT_GREEN, green);
      write_weight(CSR_WEIGHT_BLUE, blue);
   endtask

   // keeps the queue short so random picks see a fresh palette
   task automatic queue_request(input logic cmd, input int red, input int green,
                                input int blue, input logic [LIMIT_W-1:0] limit);
      colour_request_type rq;
      do @(negedge clock);
      while (colour_requests.size() >= 2);
      rq.cmd   = cmd;
      rq.red   = red[WANT_W-1:0];
      rq.green = green[WANT_W-1:0];
      rq.blue  = blue[WANT_W-1:0];
      rq.limit = limit;
      colour_requests.push_back(rq);
   endtask

   task automatic random_requests(input int count);
      int          k;
      int          c;
      int          pick;
      int          comp [3];
      logic        cmd;
      logic [LIMIT_W-1:0] limit;
      int unsigned style;
      for (k = 0; k < count; k++) begin
         cmd   = ($urandom_range(99) < 60) ? CMD_ALLOC : CMD_FIND;
         style = $urandom_range(9);
         if (style < 4) begin
            // near a stored colour, small distances against the limit
            do pick = $urandom_range(ENTRIES - 1);
            while (!shadow_used[pick]);
            for (c = 0; c < 3; c++)
               comp[c] = int'(shadow_colour[pick][c*COMP_W +: COMP_W])
                       + int'($urandom_range(16)) - 8;
         end else if (style < 8) begin
            for (c = 0; c < 3; c++) comp[c] = $urandom_range(COMP_MAX);
         end else begin
            // whole signed range, clamping on both sides
            for (c = 0; c < 3; c++) comp[c] = int'($urandom_range(4095)) - 2048;
         end
         case ($urandom_range(5))
            0:       limit = '0;
            1:       limit = DIST_SAT;
            // log spread over the whole limit range
            default: limit = LIMIT_W'($urandom >> $urandom_range(31));
         endcase
         queue_request(cmd, comp[2], comp[1], comp[0], limit);
      end
   endtask

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------

   initial begin
      csr_write_en        <= 1'b0;
      csr_index           <= CSR_WEIGHT_RED;
      csr_wdata           <= '0;

      // palette after reset: black at 0, white at the top, both in use
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_colour[i] = '0;
         shadow_used[i]   = 1'b0;
      end
      shadow_colour[ENTRIES-1] = WHITE;
      shadow_used[0]           = 1'b1;
      shadow_used[ENTRIES-1]   = 1'b1;
      shadow_free              = ENTRIES - 2;
      gain_red                 = WEIGHT_RED_RST;
      gain_green               = WEIGHT_GREEN_RST;
      gain_blue                = WEIGHT_BLUE_RST;

      // sender mostly busy, receiver mostly stalled
      send_idle_pct = 10;
      recv_idle_pct = 86;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // full weights while only white is searchable: distance past 31 bits
      set_weights(10'd1023, 10'd1023, 10'd1023);
      queue_request(CMD_FIND,  0, 0, 0, DIST_SAT);
      queue_request(CMD_FIND,  -2048, -1, -2048, '0);
      // saturated best above the largest limit still allocates
      queue_request(CMD_ALLOC, -1, -2048, 0, DIST_SAT);
      // black now found at entry 1, entry 0 is never a candidate
      queue_request(CMD_FIND,  0, 0, 0, DIST_SAT);

      // back to reset weights, spare index write must be ignored
      set_weights(WEIGHT_RED_RST, WEIGHT_GREEN_RST, WEIGHT_BLUE_RST);
      write_weight(CSR_SPARE, '1);
      queue_request(CMD_FIND,  255, 255, 255, '0);
      queue_request(CMD_FIND,  2047, 2047, 2047, '0);
      queue_request(CMD_FIND,  2047, -2048, 255, DIST_SAT);
      queue_request(CMD_ALLOC, 10, 20, 30, '0);
      // exact match, no second entry
      queue_request(CMD_ALLOC, 10, 20, 30, '0);
      queue_request(CMD_ALLOC, 90, 100, 100, '0);
      queue_request(CMD_ALLOC, 110, 100, 100, '0);
      // equal distance to both greys, lower index wins
      queue_request(CMD_FIND,  100, 100, 100, DIST_SAT);
      queue_request(CMD_ALLOC, 100, 100, 100, DIST_SAT);
      // limit one below the best distance of 956800
      queue_request(CMD_ALLOC, 100, 100, 100, 31'd956799);
      queue_request(CMD_ALLOC, 100, 100, 100, '0);
      queue_request(CMD_FIND,  2047, 2047, 2047, 31'h7fff_ffff);
      queue_request(CMD_ALLOC, 1024, 512, 256, 31'h5555_5555);
      queue_request(CMD_ALLOC, 128, 64, 32, 31'h2aaa_aaaa);
      queue_request(CMD_FIND,  1, 2, 3, 31'd1);

      // random traffic with reset weights, sender holds off halfway
      random_requests(150);
      wait_idle();
      random_requests(150);

      set_weights(10'd1023, 10'd1023, 10'd1023);
      random_requests(200);

      // receiver mostly ready, sender mostly idle
      wait_idle();
      send_idle_pct = 86;
      recv_idle_pct = 10;
      // zero weights: every distance is zero, ties everywhere
      set_weights('0, '0, '0);
      random_requests(150);

      set_weights(WEIGHT_W'($urandom_range(1023)), WEIGHT_W'($urandom_range(1023)),
                  WEIGHT_W'($urandom_range(1023)));
      random_requests(330);

      // no idling on either side
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      set_weights(10'd1023, '0, 10'd1);
      random_requests(200);

      set_weights(WEIGHT_W'($urandom_range(1023)), WEIGHT_W'($urandom_range(1023)),
                  WEIGHT_W'($urandom_range(1023)));
      random_requests(350);

      // let any stray response show up before the verdict
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

/* sim.f */
sv/pnma_pkg.sv
sv/pnma_req_if.sv
sv/pnma_rsp_if.sv
sv/pnma_ram.sv
sv/pnma_dist.sv
sv/palette_nearest_match_allocator_core.sv
tb/sv/tb_top.sv
